@@ sv/assert_macros.svh @@
// Assertion macros for the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked implication check, disabled while reset is asserted
`define CTN_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also runs during reset
`define CTN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTN_ASSERT(label, clk, rstn, prop, msg)
`define CTN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ sv/ctn_pkg.sv @@
// Shared types and constants for the ticks-to-nanoseconds converter
`timescale 1ns / 1ps
package ctn_pkg;
    localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
    // Largest seconds count whose product with NS_PER_SEC fits in 64 bits
    localparam logic [63:0] SECS_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF / NS_PER_SEC;
    localparam int          DIV1_STEPS   = 64;
    localparam int          DIV2_STEPS   = 30;

    typedef enum logic {
        REG_TICK_OFFSET = 1'b0,
        REG_COUNTER_FREQ = 1'b1
    } reg_index_t;

    // Request as it travels through the divider cells
    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [63:0] num;
        logic [31:0] rem;
        logic [63:0] quo;
        logic [63:0] aux;
    } div_t;
endpackage

@@ sv/ctn_div_cell.sv @@
// One restoring-division cell: develops one quotient bit per request
`timescale 1ns / 1ps
module ctn_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [31:0]        freq,
    input  ctn_pkg::div_t      d_in,
    output ctn_pkg::div_t      d_out
);
    import ctn_pkg::*;

    div_t        d_reg;
    div_t        d_next;
    logic [32:0] trial;
    logic        take;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial  = {d_in.rem, d_in.num[63]};
        take   = trial >= {1'b0, freq};
        d_next = d_in;
        d_next.num = {d_in.num[62:0], 1'b0};
        d_next.quo = {d_in.quo[62:0], take};
        d_next.rem = take ? 32'(trial - {1'b0, freq}) : trial[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= d_next.valid;
        end
        if (en) begin
            d_reg.ok  <= d_next.ok;
            d_reg.num <= d_next.num;
            d_reg.rem <= d_next.rem;
            d_reg.quo <= d_next.quo;
            d_reg.aux <= d_next.aux;
        end
    end

    assign d_out = d_reg;
endmodule

@@ sv/counter_ticks_to_nanoseconds.sv @@
// Pipeline from input request to result: offset stage, 64 divider cells,
// one multiply stage, 30 divider cells, output stage.
// Throughput: one request per cycle; the pipeline moves whenever the output
// register is empty or being taken, one quotient bit per cell.
// Reset (aresetn, synchronous, active low) empties the pipeline and clears
// tick_offset and counter_frequency to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module counter_ticks_to_nanoseconds (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_raw_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_nanoseconds,
    output logic        m_conversion_ok
);
    import ctn_pkg::*;

    logic [63:0] tick_offset_reg;
    logic [31:0] counter_freq_reg;
    logic        adv;

    div_t        c1 [0:DIV1_STEPS];
    div_t        c2 [0:DIV2_STEPS];
    div_t        off_reg;
    div_t        off_next;

    logic        mul_valid_reg;
    logic        mul_ok_reg;
    logic [61:0] plo_reg;
    logic [32:0] phi_reg;
    logic [61:0] prem_reg;

    logic [63:0] whole;
    logic [64:0] sum;
    logic        fin_ok;
    logic        m_valid_reg;
    logic [63:0] m_ns_reg;
    logic        m_ok_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_offset_reg  <= '0;
            counter_freq_reg <= '0;
        end else if (cfg_wen) begin
            unique case (reg_index_t'(cfg_index))
                REG_TICK_OFFSET:  tick_offset_reg  <= cfg_wdata;
                REG_COUNTER_FREQ: counter_freq_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless the result is stalled
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Offset stage: 65-bit sum, carry decides range for either sign
    always_comb begin
        logic [64:0] osum;
        osum = {1'b0, s_raw_ticks} + {1'b0, tick_offset_reg};
        off_next.valid = s_valid;
        // positive: carry means overflow; negative: carry means no underflow
        off_next.ok    = (counter_freq_reg != '0) &&
                         (osum[64] == tick_offset_reg[63]);
        off_next.num   = osum[63:0];
        off_next.rem   = '0;
        off_next.quo   = '0;
        off_next.aux   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg.valid <= 1'b0;
        end else if (adv) begin
            off_reg.valid <= off_next.valid;
        end
        if (adv) begin
            off_reg.ok  <= off_next.ok;
            off_reg.num <= off_next.num;
            off_reg.rem <= off_next.rem;
            off_reg.quo <= off_next.quo;
            off_reg.aux <= off_next.aux;
        end
    end

    // Seconds and remainder: 64 cells
    assign c1[0] = off_reg;
    for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
        ctn_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .freq    (counter_freq_reg),
            .d_in    (c1[i]),
            .d_out   (c1[i+1])
        );
    end

    // Multiply stage: seconds split in 32 + 3 bits, remainder times 1e9
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= c1[DIV1_STEPS].valid;
        end
        if (adv) begin
            mul_ok_reg <= c1[DIV1_STEPS].ok && (c1[DIV1_STEPS].quo <= SECS_LIMIT);
            plo_reg    <= 62'(c1[DIV1_STEPS].quo[31:0]) * 62'(NS_PER_SEC);
            phi_reg    <= 33'(c1[DIV1_STEPS].quo[34:32]) * 33'(NS_PER_SEC);
            prem_reg   <= 62'(c1[DIV1_STEPS].rem) * 62'(NS_PER_SEC);
        end
    end

    // Combine partial products; fraction division starts from top 32 bits
    assign whole = 64'({2'b0, plo_reg}) + {phi_reg[31:0], 32'b0};
    always_comb begin
        c2[0].valid = mul_valid_reg;
        c2[0].ok    = mul_ok_reg;
        c2[0].rem   = prem_reg[61:30];
        c2[0].num   = {prem_reg[29:0], 34'b0};
        c2[0].quo   = '0;
        c2[0].aux   = whole;
    end

    // Fraction: 30 cells, quotient below 1e9
    for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
        ctn_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .freq    (counter_freq_reg),
            .d_in    (c2[j]),
            .d_out   (c2[j+1])
        );
    end

    // Final add with overflow flag, output register
    assign sum    = {1'b0, c2[DIV2_STEPS].aux} + 65'(c2[DIV2_STEPS].quo[29:0]);
    assign fin_ok = c2[DIV2_STEPS].ok && !sum[64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= c2[DIV2_STEPS].valid;
        end
        if (adv) begin
            m_ok_reg <= fin_ok;
            m_ns_reg <= fin_ok ? sum[63:0] : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nanoseconds   = m_ns_reg;
    assign m_conversion_ok = m_ok_reg;

    `CTN_ASSERT(a_fail_zero, aclk, aresetn, (m_valid && !m_conversion_ok) |-> (m_nanoseconds == '0), "failed conversion must report zero")
    `CTN_ASSERT(a_zero_freq, aclk, aresetn, (m_valid && counter_freq_reg == '0) |-> !m_conversion_ok, "zero frequency must fail")
    `CTN_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")
endmodule
